### src/assert_macros.svh
// Assertion macros used by the controller of the key hash block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### src/bkhb_pkg.sv
// Package: constants, command/status types and mix schedule for the key hash block.
`default_nettype none
package bkhb_pkg;

    localparam logic [31:0] GOLDEN_WORD  = 32'h9e37_79b9;
    localparam logic [31:0] INIT_RESET   = 32'hDEAD_BEEF;
    localparam logic [30:0] BUCKET_RESET = 31'd1024;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_INIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BUCKET = 2'd1;

    localparam logic [3:0] BLOCK_LAST_POS = 4'd11;
    localparam logic [3:0] MIX_LAST_STEP  = 4'd8;
    localparam logic [4:0] DIV_LAST_BIT   = 5'd31;

    // which word a mix step rewrites
    localparam logic [1:0] MIX_SEL_A = 2'd0;
    localparam logic [1:0] MIX_SEL_B = 2'd1;
    localparam logic [1:0] MIX_SEL_C = 2'd2;

    typedef struct packed {
        logic       take;     // accept a key beat (byte and/or end)
        logic       mix;      // run one mix step
        logic [3:0] step;     // mix step 0..8
        logic       fin;      // add length and tail to c, clear remainder
        logic       div;      // one remainder bit
        logic [4:0] bit_idx;  // bit of c fed into the remainder
        logic       load;     // move result into output register
    } t_dp_cmd;

    typedef struct packed {
        logic blk_full;   // next byte closes a 12-byte block
        logic out_free;   // output register can take a result
    } t_dp_sts;

    function automatic logic [1:0] mix_sel(input logic [3:0] step);
        logic [1:0] s;
        unique case (step)
            4'd0, 4'd3, 4'd6: s = MIX_SEL_A;
            4'd1, 4'd4, 4'd7: s = MIX_SEL_B;
            default:          s = MIX_SEL_C;
        endcase
        return s;
    endfunction

    function automatic logic [4:0] mix_shift(input logic [3:0] step);
        logic [4:0] s;
        unique case (step)
            4'd0:    s = 5'd13;
            4'd1:    s = 5'd8;
            4'd2:    s = 5'd13;
            4'd3:    s = 5'd12;
            4'd4:    s = 5'd16;
            4'd5:    s = 5'd5;
            4'd6:    s = 5'd3;
            4'd7:    s = 5'd10;
            default: s = 5'd15;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

### src/bkhb_dp.sv
// Datapath: mixing words, key bookkeeping, remainder unit, config and output registers.
`default_nettype none
module bkhb_dp import bkhb_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [31:0]          i_cfg_data,
    input  wire logic [7:0]           i_byte,
    input  wire logic                 i_present,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_sts                   o_sts,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output logic [31:0]               o_hash,
    output logic [30:0]               o_bucket
);

    logic [31:0] r_init, bcount_ext;
    logic [30:0] r_bcount;
    logic [31:0] r_a, r_b, r_c, r_len;
    logic [23:0] r_tail;
    logic [3:0]  r_pos;
    logic        r_in_key;
    logic [30:0] r_rem;
    logic        r_ov;
    logic [31:0] r_hash;
    logic [30:0] r_bkt;

    logic [31:0] base_a, base_b, base_c, base_len;
    logic [23:0] base_tail;
    logic [3:0]  base_pos;
    logic [31:0] n_a, n_b, n_c, n_len;
    logic [23:0] n_tail;
    logic [3:0]  n_pos;
    logic [31:0] mx_x, mx_y, mx_z, mx_src, mx_new;
    logic [1:0]  sel;
    logic [4:0]  amt;
    logic [31:0] div_t;
    logic        div_ge;

    assign bcount_ext = {1'b0, r_bcount};

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init   <= INIT_RESET;
            r_bcount <= BUCKET_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_IDX_INIT)   r_init   <= i_cfg_data;
            if (i_cfg_idx == CFG_IDX_BUCKET) r_bcount <= i_cfg_data[30:0];
        end
    end

    // key start reloads the words
    always_comb begin
        base_a    = r_in_key ? r_a    : GOLDEN_WORD;
        base_b    = r_in_key ? r_b    : GOLDEN_WORD;
        base_c    = r_in_key ? r_c    : r_init;
        base_len  = r_in_key ? r_len  : 32'd0;
        base_tail = r_in_key ? r_tail : 24'd0;
        base_pos  = r_in_key ? r_pos  : 4'd0;
    end

    // one mix step rewrites one word
    always_comb begin
        sel = mix_sel(i_cmd.step);
        amt = mix_shift(i_cmd.step);
        unique case (sel)
            MIX_SEL_A: begin mx_x = r_a; mx_y = r_b; mx_z = r_c; mx_src = r_c; end
            MIX_SEL_B: begin mx_x = r_b; mx_y = r_c; mx_z = r_a; mx_src = r_a; end
            default:   begin mx_x = r_c; mx_y = r_a; mx_z = r_b; mx_src = r_b; end
        endcase
        mx_new = (mx_x - mx_y - mx_z) ^
                 ((sel == MIX_SEL_B) ? (mx_src << amt) : (mx_src >> amt));
    end

    always_comb begin
        n_a    = r_a;
        n_b    = r_b;
        n_c    = r_c;
        n_len  = r_len;
        n_tail = r_tail;
        n_pos  = r_pos;
        if (i_cmd.take) begin
            n_a    = base_a;
            n_b    = base_b;
            n_c    = base_c;
            n_len  = base_len;
            n_tail = base_tail;
            n_pos  = base_pos;
            if (i_present) begin
                n_len = base_len + 32'd1;
                n_pos = base_pos + 4'd1;
                // byte lane within each word is the low two position bits
                priority if (base_pos < 4'd4) begin
                    n_a = base_a + ({24'd0, i_byte} << {base_pos[1:0], 3'b000});
                end else if (base_pos < 4'd8) begin
                    n_b = base_b + ({24'd0, i_byte} << {base_pos[1:0], 3'b000});
                end else if (base_pos < BLOCK_LAST_POS) begin
                    n_tail = base_tail | 24'(({24'd0, i_byte} << {base_pos[1:0], 3'b000}));
                end else begin
                    n_c    = base_c + {i_byte, base_tail};
                    n_tail = 24'd0;
                    n_pos  = 4'd0;
                end
            end
        end else if (i_cmd.mix) begin
            unique case (sel)
                MIX_SEL_A: n_a = mx_new;
                MIX_SEL_B: n_b = mx_new;
                default:   n_c = mx_new;
            endcase
        end else if (i_cmd.fin) begin
            n_c = r_c + r_len + {r_tail, 8'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_b    <= n_b;
        r_c    <= n_c;
        r_len  <= n_len;
        r_tail <= n_tail;
        r_pos  <= n_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_key <= 1'b0;
        end else if (i_cmd.take) begin
            r_in_key <= 1'b1;
        end else if (i_cmd.load) begin
            r_in_key <= 1'b0;
        end
    end

    // restoring remainder, one bit of c per cycle, msb first
    assign div_t  = {r_rem, r_c[i_cmd.bit_idx]};
    assign div_ge = div_t >= bcount_ext;

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_rem <= 31'd0;
        end else if (i_cmd.div) begin
            r_rem <= div_ge ? 31'(div_t - bcount_ext) : div_t[30:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.load) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hash <= r_c;
            r_bkt  <= (r_bcount == 31'd0) ? 31'd0 : r_rem;
        end
    end

    assign o_sts.blk_full = r_in_key && (r_pos == BLOCK_LAST_POS);
    assign o_sts.out_free = !r_ov || i_out_ready;
    assign o_out_valid    = r_ov;
    assign o_hash         = r_hash;
    assign o_bucket       = r_bkt;

endmodule
`default_nettype wire

### src/bkhb_ctrl.sv
// Controller: sequences byte intake, block mix, length/tail add, final mix, remainder and result load.
`default_nettype none
`include "assert_macros.svh"
module bkhb_ctrl import bkhb_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_in_present,
    input  wire logic    i_in_last,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_BMIX = 3'd1;
    localparam logic [2:0] S_FIN  = 3'd2;
    localparam logic [2:0] S_FMIX = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_LOAD = 3'd5;

    logic [2:0] r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic       r_last, n_last;
    logic       take;

    assign o_in_ready = (r_state == S_IDLE);
    assign take       = i_in_valid && o_in_ready && (i_in_present || i_in_last);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + 5'd1;
        n_last  = r_last;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = 5'd0;
                if (take) begin
                    n_last = i_in_last;
                    if (i_in_present && i_sts.blk_full) begin
                        n_state = S_BMIX;
                    end else if (i_in_last) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_BMIX: begin
                if (r_cnt[3:0] == MIX_LAST_STEP) begin
                    n_cnt   = 5'd0;
                    n_state = r_last ? S_FIN : S_IDLE;
                end
            end
            S_FIN: begin
                n_cnt   = 5'd0;
                n_state = S_FMIX;
            end
            S_FMIX: begin
                if (r_cnt[3:0] == MIX_LAST_STEP) begin
                    n_cnt   = 5'd0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == DIV_LAST_BIT) begin
                    n_cnt   = 5'd0;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_cnt = 5'd0;
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: begin
                n_cnt   = 5'd0;
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 5'd0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_last  <= n_last;
        end
    end

    always_comb begin
        o_cmd.take    = take;
        o_cmd.mix     = (r_state == S_BMIX) || (r_state == S_FMIX);
        o_cmd.step    = r_cnt[3:0];
        o_cmd.fin     = (r_state == S_FIN);
        o_cmd.div     = (r_state == S_DIV);
        o_cmd.bit_idx = ~r_cnt;
        o_cmd.load    = (r_state == S_LOAD) && i_sts.out_free;
    end

    `ASSERT_IMP(a_mix_step_range, (r_state == S_BMIX || r_state == S_FMIX), (r_cnt <= 5'd8), "mix step counter out of range")
    `ASSERT_NXT(a_final_mix_to_div, (r_state == S_FMIX && r_cnt == 5'd8), (r_state == S_DIV && r_cnt == 5'd0), "final mix did not hand over to remainder")
    `ASSERT_NXT(a_block_mix_resume, (r_state == S_BMIX && r_cnt == 5'd8 && !r_last), (r_state == S_IDLE), "block mix did not return to intake")
    `ASSERT_NXT(a_load_frees_intake, (o_cmd.load), (r_state == S_IDLE), "result load left intake blocked")

endmodule
`default_nettype wire

### src/byte_key_hash_bucket.sv
// Top level: streaming lookup2 key hash with bucket reduction.
// Intake: one byte per cycle inside a block; every 12th byte starts a block mix, during which
// s_axis_tready is low. End of key: optional block mix, length/tail add, final mix, remainder
// (one bit per cycle) and result load, after which m_axis_tvalid rises; no new key is taken
// before the result is loaded.
// Reset (i_rst_n low, synchronous): idle, no key open, output empty, config at reset values.
`default_nettype none
module byte_key_hash_bucket import bkhb_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // config write port
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,     // 0 init_value, 1 bucket_count
    input  wire logic [31:0]          i_cfg_data,
    // key byte stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [7:0]           s_axis_tdata,  // [7:0] key_byte
    input  wire logic                 s_axis_tuser,  // [0] byte_present
    input  wire logic                 s_axis_tlast,  // last_byte
    // result stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [63:0]               m_axis_tdata   // [31:0] hash_value, [62:32] bucket_index
);

    t_dp_cmd     cmd;
    t_dp_sts     sts;
    logic [31:0] hash;
    logic [30:0] bucket;

    // sequencer: owns the step/bit counter and intake ready
    bkhb_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_present (s_axis_tuser),
        .i_in_last    (s_axis_tlast),
        .o_in_ready   (s_axis_tready),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    // words a/b/c, length, tail, remainder and output register
    bkhb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_byte      (s_axis_tdata),
        .i_present   (s_axis_tuser),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_hash      (hash),
        .o_bucket    (bucket)
    );

    // pad to whole bytes
    assign m_axis_tdata = {1'b0, bucket, hash};

endmodule
`default_nettype wire
